### design/scpr_pkg.sv
// Shared types and constants for the second-chance page replacer.
package scpr_pkg;

  localparam int unsigned FRAMES_DEF    = 64;
  localparam int unsigned PAGE_BITS_DEF = 16;

  localparam int unsigned PAGE_IN_W  = 16;
  localparam int unsigned SLOT_W     = 6;
  localparam int unsigned COUNT_W    = 32;
  localparam int unsigned CFG_W      = 7;
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [CFG_W-1:0] FRAMES_IN_USE_RST = 7'd64;
  localparam logic             REG_FRAMES_IN_USE = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_SWEEP
  } state_t;

endpackage

### design/scpr_page_ram.sv
// Page-number memory of the frames: one write port, one registered read port.
module scpr_page_ram #(
  parameter int unsigned DEPTH = scpr_pkg::FRAMES_DEF,
  parameter int unsigned AW    = 6,
  parameter int unsigned DW    = scpr_pkg::PAGE_BITS_DEF
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### design/second_chance_page_replacer.sv
// Top level of the second-chance (clock) page replacer.
//
// Usage: raise start with in_page_number while busy is low; the transaction
// is accepted at that edge and busy stays high until the result is ready.
// Exactly one result per transaction appears for one cycle with out_strobe:
// out_hit, out_frame_index and the saturating out_fault_count.
// The receiver cannot stall; each result is taken in the cycle it is shown.
// Operation: the search reads one frame page per cycle from the page memory
// through a registered read; a hit in frame k ends the search with frame k as
// its result. A miss scans all n active frames, then the clock hand steps one
// frame per cycle, clearing set reference bits, until it finds a clear one.
// busy falls in the cycle the strobe is shown, so the next transaction can be
// accepted at the edge that ends that cycle.
// Configuration: frames_in_use at byte address 0 of the APB port, to be written
// only while idle (the block itself does not enforce this); pready is always high.
// Reset (rst_n low, synchronous) clears valid and reference bits, the hand,
// the fault count and sets frames_in_use to 64; the page memory is not
// cleared and needs no clearing pass.
module second_chance_page_replacer #(
  parameter int unsigned FRAMES    = scpr_pkg::FRAMES_DEF,
  parameter int unsigned PAGE_BITS = scpr_pkg::PAGE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [scpr_pkg::PAGE_IN_W-1:0]       in_page_number,
  output logic                                 out_strobe,
  output logic                                 out_hit,
  output logic [scpr_pkg::SLOT_W-1:0]          out_frame_index,
  output logic [scpr_pkg::COUNT_W-1:0]         out_fault_count,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [scpr_pkg::APB_ADDR_W-1:0]      paddr,
  input  logic [scpr_pkg::APB_DATA_W-1:0]      pwdata,
  output logic [scpr_pkg::APB_DATA_W-1:0]      prdata,
  output logic                                 pready
);

  localparam int unsigned IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int unsigned CW = $clog2(FRAMES + 1);

  scpr_pkg::state_t state_r, state_nxt;

  logic [scpr_pkg::CFG_W-1:0]   frames_r;
  logic [FRAMES-1:0]            valid_r, valid_nxt;
  logic [FRAMES-1:0]            ref_r, ref_nxt;
  logic [IW-1:0]                clock_hand_r, clock_hand_nxt;
  logic [scpr_pkg::COUNT_W-1:0] faults_r, faults_nxt;

  logic [PAGE_BITS-1:0]         page_r, page_nxt;
  logic [CW-1:0]                n_r, n_nxt;
  logic [CW-1:0]                scan_r, scan_nxt;
  logic [IW-1:0]                cmp_idx_r, cmp_idx_nxt;
  logic                         cmp_vld_r, cmp_vld_nxt;
  logic [IW-1:0]                hand_r, hand_nxt;

  logic                         strobe_r, strobe_nxt;
  logic                         hit_r, hit_nxt;
  logic [scpr_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  logic [scpr_pkg::COUNT_W-1:0] count_r, count_nxt;

  logic [CW-1:0]                n_act;
  logic [PAGE_BITS-1:0]         ram_q;
  logic                         ram_we;
  logic                         accept;
  logic                         cfg_we;
  logic                         hit_now;
  logic                         last_cmp;
  logic                         ref_hand;
  logic [IW-1:0]                hand_inc;
  logic [IW-1:0]                hand_start;
  logic [scpr_pkg::COUNT_W-1:0] fault_inc;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite && pready
                  && (paddr[scpr_pkg::APB_ADDR_W-1] == scpr_pkg::REG_FRAMES_IN_USE);

  always_comb begin
    if (paddr[scpr_pkg::APB_ADDR_W-1] == scpr_pkg::REG_FRAMES_IN_USE) begin
      prdata = scpr_pkg::APB_DATA_W'(frames_r);
    end else begin
      prdata = '0;
    end
  end

  always_comb begin
    priority if (frames_r == '0) begin
      n_act = CW'(1);
    end else if (32'(frames_r) > 32'(FRAMES)) begin
      n_act = CW'(FRAMES);
    end else begin
      n_act = CW'(frames_r);
    end
  end

  assign busy   = (state_r != scpr_pkg::ST_IDLE);
  assign accept = start && !busy;

  assign hit_now  = cmp_vld_r && valid_r[cmp_idx_r] && (ram_q == page_r);
  assign last_cmp = cmp_vld_r && (CW'(cmp_idx_r) == (n_r - CW'(1)));
  assign ref_hand = ref_r[hand_r];
  assign hand_inc = (CW'(hand_r) == (n_r - CW'(1))) ? '0 : hand_r + IW'(1);
  assign hand_start = (CW'(clock_hand_r) >= n_r) ? '0 : clock_hand_r;
  assign fault_inc  = (faults_r == '1) ? faults_r : faults_r + scpr_pkg::COUNT_W'(1);
  assign ram_we     = (state_r == scpr_pkg::ST_SWEEP) && !ref_hand;

  scpr_page_ram #(
    .DEPTH (FRAMES),
    .AW    (IW),
    .DW    (PAGE_BITS)
  ) u_page_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (hand_r),
    .wdata (page_r),
    .raddr (scan_r[IW-1:0]),
    .rdata (ram_q)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      scpr_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = scpr_pkg::ST_SEARCH;
        end
      end
      scpr_pkg::ST_SEARCH: begin
        priority if (hit_now) begin
          state_nxt = scpr_pkg::ST_IDLE;
        end else if (last_cmp) begin
          state_nxt = scpr_pkg::ST_SWEEP;
        end
      end
      scpr_pkg::ST_SWEEP: begin
        if (!ref_hand) begin
          state_nxt = scpr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = scpr_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    valid_nxt      = valid_r;
    ref_nxt        = ref_r;
    clock_hand_nxt = clock_hand_r;
    faults_nxt     = faults_r;
    page_nxt       = page_r;
    n_nxt          = n_r;
    scan_nxt       = scan_r;
    cmp_idx_nxt    = cmp_idx_r;
    cmp_vld_nxt    = 1'b0;
    hand_nxt       = hand_r;
    strobe_nxt     = 1'b0;
    hit_nxt        = hit_r;
    slot_nxt       = slot_r;
    count_nxt      = count_r;
    unique case (state_r)
      scpr_pkg::ST_IDLE: begin
        if (accept) begin
          page_nxt = PAGE_BITS'(in_page_number);
          n_nxt    = n_act;
          scan_nxt = '0;
        end
      end
      scpr_pkg::ST_SEARCH: begin
        scan_nxt    = scan_r + CW'(1);
        cmp_idx_nxt = scan_r[IW-1:0];
        cmp_vld_nxt = (scan_r < n_r);
        priority if (hit_now) begin
          ref_nxt[cmp_idx_r] = 1'b1;
          strobe_nxt         = 1'b1;
          hit_nxt            = 1'b1;
          slot_nxt           = scpr_pkg::SLOT_W'(cmp_idx_r);
          count_nxt          = faults_r;
          cmp_vld_nxt        = 1'b0;
        end else if (last_cmp) begin
          hand_nxt    = hand_start;
          cmp_vld_nxt = 1'b0;
        end
      end
      scpr_pkg::ST_SWEEP: begin
        if (ref_hand) begin
          ref_nxt[hand_r] = 1'b0;
          hand_nxt        = hand_inc;
        end else begin
          valid_nxt[hand_r] = 1'b1;
          clock_hand_nxt    = hand_inc;
          faults_nxt        = fault_inc;
          strobe_nxt        = 1'b1;
          hit_nxt           = 1'b0;
          slot_nxt          = scpr_pkg::SLOT_W'(hand_r);
          count_nxt         = fault_inc;
        end
      end
      default: begin
        cmp_vld_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= scpr_pkg::ST_IDLE;
      frames_r     <= scpr_pkg::FRAMES_IN_USE_RST;
      valid_r      <= '0;
      ref_r        <= '0;
      clock_hand_r <= '0;
      faults_r     <= '0;
      cmp_vld_r    <= 1'b0;
      strobe_r     <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      ref_r        <= ref_nxt;
      clock_hand_r <= clock_hand_nxt;
      faults_r     <= faults_nxt;
      cmp_vld_r    <= cmp_vld_nxt;
      strobe_r     <= strobe_nxt;
      if (cfg_we) begin
        frames_r <= pwdata[scpr_pkg::CFG_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    page_r    <= page_nxt;
    n_r       <= n_nxt;
    scan_r    <= scan_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hand_r    <= hand_nxt;
    hit_r     <= hit_nxt;
    slot_r    <= slot_nxt;
    count_r   <= count_nxt;
  end

  assign out_strobe      = strobe_r;
  assign out_hit         = hit_r;
  assign out_frame_index = slot_r;
  assign out_fault_count = count_r;

endmodule
